// ===== src/mpq_pkg.sv =====
// Shared types and constants for the sorted max-priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package mpq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;
  localparam int COUNT_OUT_W   = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd1;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/mpq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and exchanges
// data with its neighbors. Depends on mpq_pkg.
`default_nettype none

module mpq_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 7
) (
  input  wire logic                                   clk,
  input  wire mpq_pkg::cell_cmd_t                     cmd,
  input  wire logic        [COUNT_W-1:0]              count,
  input  wire logic signed [mpq_pkg::DATA_W-1:0]      new_value,
  input  wire logic signed [mpq_pkg::DATA_W-1:0]      prev_value,
  input  wire logic                                   prev_ge,
  input  wire logic signed [mpq_pkg::DATA_W-1:0]      next_value,
  output logic signed      [mpq_pkg::DATA_W-1:0]      value,
  output logic                                        ge
);

  logic                                  occupied;
  logic signed [mpq_pkg::DATA_W-1:0]     value_next;

  assign occupied = (count > COUNT_W'(INDEX));

  // An occupied entry that is greater than or equal to the new value stays
  // ahead of it, so equal values keep their arrival order.
  assign ge = occupied && (value >= new_value);

  always_comb begin
    value_next = value;
    if (cmd.insert_en) begin
      if (!ge) begin
        value_next = prev_ge ? new_value : prev_value;
      end
    end else if (cmd.remove_en) begin
      value_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ===== src/max_priority_queue_top.sv =====
// Sorted max-priority queue: top level with the cell chain, count and result.
// Depends on mpq_pkg and mpq_cell.
// done is high in the cycle after start is taken.
// Throughput: one item per cycle; every cell compares and shifts in parallel.
// busy stays low, and the receiver cannot stall the result strobe.
// Reset empties the queue at once by clearing the entry count.
`default_nettype none

module max_priority_queue_top #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic                                      req_type,
  input  wire logic signed [mpq_pkg::DATA_W-1:0]         value,
  output logic                                           done,
  output logic signed      [mpq_pkg::DATA_W-1:0]         top_value,
  output logic                                           queue_empty,
  output logic             [mpq_pkg::COUNT_OUT_W-1:0]    entry_count,
  output logic                                           insert_dropped
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [COUNT_W-1:0]                 count;
  logic [COUNT_W-1:0]                 count_next;
  logic                               dropped;
  logic                               accept;
  logic                               full;
  mpq_pkg::cell_cmd_t                 cmd;
  logic signed [mpq_pkg::DATA_W-1:0]  cell_value [DEPTH];
  logic                               cell_ge    [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(DEPTH));

  always_comb begin
    cmd.insert_en = accept && (req_type == mpq_pkg::REQ_INSERT) && !full;
    cmd.remove_en = accept && (req_type == mpq_pkg::REQ_REMOVE) && (count != '0);
  end

  always_comb begin
    count_next = count;
    if (cmd.insert_en) begin
      count_next = count + COUNT_W'(1);
    end else if (cmd.remove_en) begin
      count_next = count - COUNT_W'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        mpq_cell #(
          .INDEX   (gi),
          .COUNT_W (COUNT_W)
        ) u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .count      (count),
          .new_value  (value),
          .prev_value (value),
          .prev_ge    (1'b1),
          .next_value (cell_value[gi+1]),
          .value      (cell_value[gi]),
          .ge         (cell_ge[gi])
        );
      end else if (gi == DEPTH - 1) begin : g_tail
        mpq_cell #(
          .INDEX   (gi),
          .COUNT_W (COUNT_W)
        ) u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .count      (count),
          .new_value  (value),
          .prev_value (cell_value[gi-1]),
          .prev_ge    (cell_ge[gi-1]),
          .next_value (cell_value[gi]),
          .value      (cell_value[gi]),
          .ge         (cell_ge[gi])
        );
      end else begin : g_mid
        mpq_cell #(
          .INDEX   (gi),
          .COUNT_W (COUNT_W)
        ) u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .count      (count),
          .new_value  (value),
          .prev_value (cell_value[gi-1]),
          .prev_ge    (cell_ge[gi-1]),
          .next_value (cell_value[gi+1]),
          .value      (cell_value[gi]),
          .ge         (cell_ge[gi])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      done    <= 1'b0;
      dropped <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
      if (accept) begin
        dropped <= (req_type == mpq_pkg::REQ_INSERT) && full;
      end
    end
  end

  // The result is read straight from the chain head and the count register.
  assign queue_empty    = (count == '0);
  assign top_value      = queue_empty ? mpq_pkg::EMPTY_TOP : cell_value[0];
  assign entry_count    = mpq_pkg::COUNT_OUT_W'(count);
  assign insert_dropped = dropped;

endmodule

`default_nettype wire

// ===== tb/max_priority_queue_top_test.sv =====
// Self-checking testbench for the sorted max-priority queue top level.
// Depends on mpq_pkg and max_priority_queue_top; a local predictor keeps its own
// sorted copy of the queue and checks every result strobe against it.
`default_nettype none

module max_priority_queue_top_test;

  localparam int QDEPTH       = mpq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 1000;

  typedef struct {
    logic                              req;
    logic signed [mpq_pkg::DATA_W-1:0] val;
    int                                idle_pct;
    bit                                drain;
  } queue_req_t;

  typedef struct {
    logic signed [mpq_pkg::DATA_W-1:0] top;
    logic                              empty;
    logic [mpq_pkg::COUNT_OUT_W-1:0]   count;
    logic                              dropped;
  } queue_result_t;

  logic                                     clk = 1'b0;
  logic                                     rst = 1'b1;
  logic                                     start = 1'b0;
  logic                                     req_type = mpq_pkg::REQ_INSERT;
  logic signed [mpq_pkg::DATA_W-1:0]        value = '0;
  logic                                     busy;
  logic                                     done;
  logic signed [mpq_pkg::DATA_W-1:0]        top_value;
  logic                                     queue_empty;
  logic        [mpq_pkg::COUNT_OUT_W-1:0]   entry_count;
  logic                                     insert_dropped;

  queue_req_t    request_queue[$];
  queue_result_t expected_results[$];

  // Predictor state: values held largest first.
  logic signed [mpq_pkg::DATA_W-1:0] held_values[QDEPTH];
  int held_count;

  int item_total;
  int accepted_total;
  int fail_count;
  int idle_cycles;
  int n_insert, n_remove, n_refused, n_empty_remove, peak_count;

  max_priority_queue_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .value         (value),
    .done          (done),
    .top_value     (top_value),
    .queue_empty   (queue_empty),
    .entry_count   (entry_count),
    .insert_dropped(insert_dropped)
  );

  always #10 clk = ~clk;

  function automatic queue_result_t apply_request(logic req,
                                                  logic signed [mpq_pkg::DATA_W-1:0] v);
    queue_result_t r;
    int pos;
    r.dropped = 1'b0;
    if (req == mpq_pkg::REQ_INSERT) begin
      n_insert++;
      if (held_count >= QDEPTH) begin
        r.dropped = 1'b1;
        n_refused++;
      end else begin
        // Equal values stay ahead of the newcomer, so ties leave in arrival order.
        pos = 0;
        while (pos < held_count && held_values[pos] >= v) pos++;
        for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
        held_values[pos] = v;
        held_count++;
      end
    end else begin
      n_remove++;
      if (held_count == 0) begin
        n_empty_remove++;
      end else begin
        for (int i = 1; i < held_count; i++) held_values[i-1] = held_values[i];
        held_count--;
      end
    end
    if (held_count > peak_count) peak_count = held_count;
    r.empty = (held_count == 0);
    r.top   = r.empty ? mpq_pkg::EMPTY_TOP : held_values[0];
    r.count = held_count[mpq_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [mpq_pkg::DATA_W-1:0] pick_value();
    logic signed [mpq_pkg::DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = int'($urandom_range(8)) - 4;
      6:          v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      7:          v = mpq_pkg::EMPTY_TOP;
      default:    v = $urandom_range(255);
    endcase
    return v;
  endfunction

  task automatic add_request(logic req, logic signed [mpq_pkg::DATA_W-1:0] v,
                             int idle_pct, bit drain);
    queue_req_t q;
    q.req      = req;
    q.val      = v;
    q.idle_pct = idle_pct;
    q.drain    = drain;
    request_queue.push_back(q);
    item_total++;
  endtask

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Driver: presents the oldest pending request, idling at the rate it carries.
  always @(posedge clk) begin : drive_requests
    logic go;
    queue_result_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r = apply_request(req_type, value);
        expected_results.push_back(r);
        accepted_total++;
      end
      go = 1'b0;
      if (start && busy) begin
        go = 1'b1;
      end else if (request_queue.size() != 0 &&
                   $urandom_range(99) >= request_queue[0].idle_pct &&
                   !(request_queue[0].drain && expected_results.size() != 0)) begin
        go = 1'b1;
        req_type <= request_queue[0].req;
        value    <= request_queue[0].val;
        void'(request_queue.pop_front());
      end
      start <= go;
    end
  end

  // Monitor: every result strobe is one transfer matched against the oldest prediction.
  always @(posedge clk) begin : watch_results
    queue_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("top_value", longint'(e.top), longint'(top_value));
        check_field("queue_empty", longint'(e.empty), longint'(queue_empty));
        check_field("entry_count", longint'(e.count), longint'(entry_count));
        check_field("insert_dropped", longint'(e.dropped), longint'(insert_dropped));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[max_priority_queue_top] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seg_len;
    int insert_pct;
    int idle_pct;
    int made;
    bit drain;

    // Directed: empty removal, extremes, stored -1, ties, drain past empty.
    add_request(mpq_pkg::REQ_REMOVE, $urandom, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sh7fffffff, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sh80000000, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, mpq_pkg::EMPTY_TOP, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sd0, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sd5, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sd5, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, mpq_pkg::EMPTY_TOP, 0, 1'b0);
    for (int i = 0; i < 8; i++) add_request(mpq_pkg::REQ_REMOVE, $urandom, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, mpq_pkg::EMPTY_TOP, 0, 1'b0);
    add_request(mpq_pkg::REQ_REMOVE, 32'sh7fffffff, 0, 1'b0);
    add_request(mpq_pkg::REQ_REMOVE, 32'sh80000000, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sh80000000, 0, 1'b0);
    add_request(mpq_pkg::REQ_INSERT, 32'sh80000000, 0, 1'b0);

    // Random: segments biased toward filling or draining the queue, so the
    // full and empty boundaries are crossed many times.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ((made * 4) / RANDOM_ITEMS)
        0:       idle_pct = 0;
        1:       idle_pct = 56;
        2:       idle_pct = 17;
        default: idle_pct = $urandom_range(1) ? 0 : 56;
      endcase
      if (made == 0) begin
        insert_pct = 95;
        seg_len    = 120;
      end else begin
        case ($urandom_range(2))
          0:       insert_pct = 90;
          1:       insert_pct = 50;
          default: insert_pct = 10;
        endcase
        seg_len = $urandom_range(120, 40);
      end
      drain = (made == 0) || ($urandom_range(3) == 0);
      for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
        add_request(($urandom_range(99) < insert_pct) ? mpq_pkg::REQ_INSERT
                                                      : mpq_pkg::REQ_REMOVE,
                    pick_value(), idle_pct, drain && (i == 0));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_total != item_total || expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Covered %0d requests: %0d inserts (%0d refused when full), %0d removals",
             item_total, n_insert, n_refused, n_remove);
    $display("%0d removals found the queue empty; peak occupancy %0d of %0d",
             n_empty_remove, peak_count, QDEPTH);
    if (fail_count == 0) begin
      $display("[max_priority_queue_top] OK");
    end else begin
      $display("[max_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
